// ----- hdl/scs_pkg.sv -----
// Shared types and constants for the sine/cosine series unit.
`timescale 1ns / 1ps

package scs_pkg;

  // Two pi in Q8.24 and half of it (rounded down), used for the turn count.
  localparam logic [31:0]  TWOPI_Q24     = 32'd105414357;
  localparam logic [31:0]  HALF_TURN_Q24 = 32'd52707178;
  // Two pi in Q4.59, rounded to nearest.
  localparam logic [63:0]  TWOPI_Q59     = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0]  ONE_Q59       = 64'h0800_0000_0000_0000;
  // Rounding half for a Q4.59 product held at 118 fraction bits.
  localparam logic [127:0] RND_Q59       = {64'd0, 64'h0400_0000_0000_0000};
  localparam logic [63:0]  RND_Q30       = 64'h0000_0000_1000_0000;
  localparam logic [34:0]  ONE_Q30       = 35'h0_4000_0000;

  // Datapath commands.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_RED,
    DP_SQ_SET,
    DP_MUL,
    DP_SQ_DONE,
    DP_CF_SET,
    DP_CF_DONE,
    DP_TM_DONE,
    DP_ACCUM,
    DP_MAG,
    DP_RND,
    DP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [2:0] red_bit;  // turn count bit under trial
    logic [1:0] pp_idx;   // partial product: bit 1 picks the a half, bit 0 the b half
  } scs_cmd_t;

endpackage

// ----- hdl/scs_intf.sv -----
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps

interface scs_req_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] angle;

  modport source (output valid, op, angle, input ready);
  modport sink   (input valid, op, angle, output ready);
endinterface

interface scs_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

// ----- hdl/scs_ctrl.sv -----
// Sequencer for the series unit: steps the datapath through reduction and terms.
`timescale 1ns / 1ps

module scs_ctrl
  import scs_pkg::*;
#(
  parameter int unsigned TERMS = 16,
  localparam int unsigned IW   = $clog2(TERMS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          emit_ok_i,
  output scs_cmd_t      cmd_o,
  output logic [IW-1:0] term_idx_o
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'h0001,
    S_RED    = 13'h0002,
    S_SQSET  = 13'h0004,
    S_MUL    = 13'h0008,
    S_DRAIN  = 13'h0010,
    S_SQDONE = 13'h0020,
    S_CFSET  = 13'h0040,
    S_CFDONE = 13'h0080,
    S_TMDONE = 13'h0100,
    S_ACCUM  = 13'h0200,
    S_MAG    = 13'h0400,
    S_RND    = 13'h0800,
    S_EMIT   = 13'h1000
  } state_e;

  typedef enum logic [1:0] {
    PH_SQ,
    PH_CF,
    PH_TM
  } phase_e;

  state_e        state_q, state_d;
  phase_e        phase_q, phase_d;
  logic [2:0]    bit_q, bit_d;
  logic [1:0]    pp_q, pp_d;
  logic [IW-1:0] idx_q, idx_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign term_idx_o = idx_q;

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    bit_d         = bit_q;
    pp_d          = pp_q;
    idx_d         = idx_q;
    cmd_o.op      = DP_NOP;
    cmd_o.red_bit = bit_q;
    cmd_o.pp_idx  = pp_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          bit_d    = 3'd4;
          state_d  = S_RED;
        end
      end
      S_RED: begin
        cmd_o.op = DP_RED;
        if (bit_q == 3'd0) begin
          state_d = S_SQSET;
        end else begin
          bit_d = bit_q - 3'd1;
        end
      end
      S_SQSET: begin
        cmd_o.op = DP_SQ_SET;
        phase_d  = PH_SQ;
        pp_d     = 2'd0;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = DP_MUL;
        pp_d     = pp_q + 2'd1;
        if (pp_q == 2'd3) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last partial product lands in the accumulator here
        case (phase_q)
          PH_SQ:   state_d = S_SQDONE;
          PH_CF:   state_d = S_CFDONE;
          PH_TM:   state_d = S_TMDONE;
          default: state_d = S_IDLE;
        endcase
      end
      S_SQDONE: begin
        cmd_o.op = DP_SQ_DONE;
        idx_d    = IW'(1);
        state_d  = S_CFSET;
      end
      S_CFSET: begin
        cmd_o.op = DP_CF_SET;
        phase_d  = PH_CF;
        pp_d     = 2'd0;
        state_d  = S_MUL;
      end
      S_CFDONE: begin
        cmd_o.op = DP_CF_DONE;
        phase_d  = PH_TM;
        pp_d     = 2'd0;
        state_d  = S_MUL;
      end
      S_TMDONE: begin
        cmd_o.op = DP_TM_DONE;
        state_d  = S_ACCUM;
      end
      S_ACCUM: begin
        cmd_o.op = DP_ACCUM;
        if (idx_q == IW'(TERMS - 1)) begin
          state_d = S_MAG;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = S_CFSET;
        end
      end
      S_MAG: begin
        cmd_o.op = DP_MAG;
        state_d  = S_RND;
      end
      S_RND: begin
        cmd_o.op = DP_RND;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (emit_ok_i) begin
          cmd_o.op = DP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_SQ;
      bit_q   <= 3'd0;
      pp_q    <= 2'd0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      bit_q   <= bit_d;
      pp_q    <= pp_d;
      idx_q   <= idx_d;
    end
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  a_accept_starts_reduction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_RED && bit_q == 3'd4))
    else $error("accepted request did not start turn reduction");

  a_emit_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && emit_ok_i) |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle after emit");

endmodule

// ----- hdl/scs_dpath.sv -----
// Datapath: turn reduction, shared 32x32 multiply-accumulate, series sum and output.
`timescale 1ns / 1ps

module scs_dpath
  import scs_pkg::*;
#(
  parameter int unsigned TERMS = 16,
  localparam int unsigned IW   = $clog2(TERMS),
  localparam int unsigned NW   = IW + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scs_cmd_t           cmd_i,
  input  logic [IW-1:0]      term_idx_i,
  input  logic               req_op_i,
  input  logic signed [31:0] req_angle_i,
  output logic               emit_ok_o,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output logic signed [31:0] rsp_value_o
);

  localparam int unsigned NT   = 2 * TERMS;
  localparam int unsigned DMAX = (2 * TERMS - 1) * (2 * TERMS - 2);
  localparam int unsigned DW   = $clog2(DMAX + 1);
  localparam int unsigned LW   = $clog2(DW + 1);
  localparam int unsigned NUMW = 64 + DW;

  // ceil(2^(63+l) / d), l = clog2(d): exact floor division of any 63-bit value by d
  // after a multiply and a right shift by 63+l. Evaluated at elaboration only.
  function automatic logic [63:0] recip_f(input int unsigned d);
    logic [NUMW-1:0] num;
    logic [NUMW-1:0] quo;
    logic [DW:0]     rem;
    int unsigned     l;
    l   = $clog2(d);
    num = (NUMW'(1) << (63 + l)) + NUMW'(d) - NUMW'(1);
    rem = '0;
    quo = '0;
    for (int b = NUMW - 1; b >= 0; b--) begin
      rem = {rem[DW-1:0], num[b]};
      if (rem >= (DW + 1)'(d)) begin
        rem    = rem - (DW + 1)'(d);
        quo[b] = 1'b1;
      end
    end
    return quo[63:0];
  endfunction

  function automatic logic [NW-1:0] req_n(input logic cos, input logic [IW-1:0] i);
    return cos ? {i, 1'b0} : {i, 1'b1};
  endfunction

  // Coefficient tables indexed by n, divisor n*(n-1).
  logic [63:0]   recip_w [NT];
  logic [DW-1:0] half_w  [NT];
  logic [LW-1:0] shift_w [NT];

  for (genvar g = 0; g < NT; g++) begin : g_tbl
    localparam int unsigned DV = (g < 2) ? 2 : g * (g - 1);
    localparam int unsigned HV = DV / 2;
    assign recip_w[g] = recip_f(DV);
    assign half_w[g]  = DW'(HV);
    assign shift_w[g] = LW'($clog2(DV));
  end

  logic               op_q, op_d;
  logic               aneg_q, aneg_d;
  logic [31:0]        rem_q, rem_d;
  logic [63:0]        x_q, x_d;
  logic [63:0]        x2_q, x2_d;
  logic [63:0]        term_q, term_d;
  logic [63:0]        sum_q, sum_d;
  logic [63:0]        opa_q, opa_d;
  logic [63:0]        opb_q, opb_d;
  logic [127:0]       acc_q, acc_d;
  logic [63:0]        pp_q, pp_d;
  logic [1:0]         pp_sh_q, pp_sh_d;
  logic               pp_vld_q, pp_vld_d;
  logic               neg_q, neg_d;
  logic [63:0]        mag_q, mag_d;
  logic               sneg_q, sneg_d;
  logic [30:0]        rnd_q, rnd_d;
  logic signed [31:0] value_q, value_d;
  logic               out_vld_q, out_vld_d;

  logic [NW-1:0]      n_w;
  logic [31:0]        amag_w;
  logic [31:0]        tw24_w;
  logic [63:0]        tw59_w;
  logic [31:0]        mul_a_w, mul_b_w;
  logic [127:0]       pp_ext_w;
  logic [63:0]        prod_w;
  logic [63:0]        cq_w;
  logic [63:0]        rsum_w;

  assign n_w       = req_n(op_q, term_idx_i);
  assign emit_ok_o = !out_vld_q || rsp_ready_i;

  always_comb begin
    amag_w   = req_angle_i[31] ? (32'd0 - req_angle_i) : req_angle_i;
    tw24_w   = TWOPI_Q24 << cmd_i.red_bit;
    tw59_w   = TWOPI_Q59 << cmd_i.red_bit;
    mul_a_w  = cmd_i.pp_idx[1] ? opa_q[63:32] : opa_q[31:0];
    mul_b_w  = cmd_i.pp_idx[0] ? opb_q[63:32] : opb_q[31:0];
    prod_w   = acc_q[122:59];
    cq_w     = 64'(acc_q[127:63] >> shift_w[n_w]);
    rsum_w   = mag_q + RND_Q30;
    case (pp_sh_q)
      2'd0:    pp_ext_w = {64'd0, pp_q};
      2'd3:    pp_ext_w = {pp_q, 64'd0};
      default: pp_ext_w = {32'd0, pp_q, 32'd0};
    endcase
  end

  always_comb begin
    op_d      = op_q;
    aneg_d    = aneg_q;
    rem_d     = rem_q;
    x_d       = x_q;
    x2_d      = x2_q;
    term_d    = term_q;
    sum_d     = sum_q;
    opa_d     = opa_q;
    opb_d     = opb_q;
    acc_d     = pp_vld_q ? (acc_q + pp_ext_w) : acc_q;
    pp_d      = mul_a_w * mul_b_w;
    pp_sh_d   = cmd_i.pp_idx;
    pp_vld_d  = (cmd_i.op == DP_MUL);
    neg_d     = neg_q;
    mag_d     = mag_q;
    sneg_d    = sneg_q;
    rnd_d     = rnd_q;
    value_d   = value_q;
    out_vld_d = out_vld_q && !rsp_ready_i;
    case (cmd_i.op)
      DP_LOAD: begin
        op_d   = req_op_i;
        aneg_d = req_angle_i[31];
        rem_d  = amag_w + HALF_TURN_Q24;
        x_d    = {req_angle_i[28:0], 35'd0};
      end
      DP_RED: begin
        // one bit of the turn count; the residual follows it modulo 2^64
        if (rem_q >= tw24_w) begin
          rem_d = rem_q - tw24_w;
          x_d   = aneg_q ? (x_q + tw59_w) : (x_q - tw59_w);
        end
      end
      DP_SQ_SET: begin
        opa_d = x_q[63] ? (64'd0 - x_q) : x_q;
        opb_d = x_q[63] ? (64'd0 - x_q) : x_q;
        acc_d = RND_Q59;
      end
      DP_SQ_DONE: begin
        x2_d   = prod_w;
        term_d = op_q ? ONE_Q59 : x_q;
        sum_d  = op_q ? ONE_Q59 : x_q;
      end
      DP_CF_SET: begin
        opa_d = x2_q + 64'(half_w[n_w]);
        opb_d = recip_w[n_w];
        acc_d = '0;
      end
      DP_CF_DONE: begin
        opa_d = term_q[63] ? (64'd0 - term_q) : term_q;
        opb_d = cq_w;
        neg_d = term_q[63];
        acc_d = RND_Q59;
      end
      DP_TM_DONE: begin
        // next term is minus the signed product
        term_d = neg_q ? prod_w : (64'd0 - prod_w);
      end
      DP_ACCUM: begin
        sum_d = sum_q + term_q;
      end
      DP_MAG: begin
        sneg_d = sum_q[63];
        mag_d  = sum_q[63] ? (64'd0 - sum_q) : sum_q;
      end
      DP_RND: begin
        rnd_d = (rsum_w[63:29] > ONE_Q30) ? ONE_Q30[30:0] : rsum_w[59:29];
      end
      DP_EMIT: begin
        value_d   = sneg_q ? (32'sd0 - $signed({1'b0, rnd_q})) : $signed({1'b0, rnd_q});
        out_vld_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      pp_vld_q  <= pp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    aneg_q  <= aneg_d;
    rem_q   <= rem_d;
    x_q     <= x_d;
    x2_q    <= x2_d;
    term_q  <= term_d;
    sum_q   <= sum_d;
    opa_q   <= opa_d;
    opb_q   <= opb_d;
    acc_q   <= acc_d;
    pp_q    <= pp_d;
    pp_sh_q <= pp_sh_d;
    neg_q   <= neg_d;
    mag_q   <= mag_d;
    sneg_q  <= sneg_d;
    rnd_q   <= rnd_d;
    value_q <= value_d;
  end

  assign rsp_valid_o = out_vld_q;
  assign rsp_value_o = value_q;

  a_emit_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_EMIT) |-> (!out_vld_q || rsp_ready_i))
    else $error("result written over one not yet taken");

  a_value_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ($signed(value_q) <= $signed(32'h4000_0000)
                && $signed(value_q) >= $signed(32'hC000_0000)))
    else $error("result outside plus or minus one");

  a_setup_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_SQ_SET || cmd_i.op == DP_CF_SET || cmd_i.op == DP_CF_DONE)
      |-> !pp_vld_q)
    else $error("accumulator preset while a partial product is pending");

endmodule

// ----- hdl/sine_cosine_series_unit.sv -----
// Top level of the sine/cosine series unit.
//
//  channel | dir | fields               | accepted when
//  req_i   | in  | op (1), angle (32 s) | req_i.valid && req_i.ready
//  rsp_o   | out | value (32 s)         | rsp_o.valid && rsp_o.ready
//
// One request at a time: the next is taken only once the previous result has been
// written to the output register. The single 32x32 multiplier builds every 64-bit
// product from four partial products, two products per series term.
// Reduction by whole turns tries the turn count bits one by one, from bit 4 to bit 0.
// Reset clears the sequencer and the valid flags only.
// The result sits in an output register; a new request is taken while it waits,
// and only the final write stalls until the previous result is gone.
`timescale 1ns / 1ps

module sine_cosine_series_unit
  import scs_pkg::*;
#(
  parameter int unsigned TERMS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  scs_req_if.sink         req_i,
  scs_rsp_if.source       rsp_o
);

  localparam int unsigned IW = $clog2(TERMS);

  scs_cmd_t      cmd;
  logic [IW-1:0] term_idx;
  logic          emit_ok;

  scs_ctrl #(
    .TERMS (TERMS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .emit_ok_i  (emit_ok),
    .cmd_o      (cmd),
    .term_idx_o (term_idx)
  );

  scs_dpath #(
    .TERMS (TERMS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .term_idx_i  (term_idx),
    .req_op_i    (req_i.op),
    .req_angle_i (req_i.angle),
    .emit_ok_o   (emit_ok),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_value_o (rsp_o.value)
  );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the sine/cosine series unit.
`timescale 1ns / 1ps

module tb;
  import scs_pkg::*;

  localparam int unsigned SERIES_TERMS = 16;
  localparam logic OP_SINE   = 1'b0;
  localparam logic OP_COSINE = 1'b1;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 240;
  localparam logic [31:0] HALF_PI_Q24 = 32'd26353589;
  localparam logic [31:0] FULL_SCALE = 32'h4000_0000;

  typedef struct {
    logic        op;
    logic [31:0] angle;
    logic [31:0] value;
  } series_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  scs_req_if req ();
  scs_rsp_if rsp ();

  sine_cosine_series_unit #(
    .TERMS(SERIES_TERMS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  always #6 clk_i = ~clk_i;

  series_result_t pending_results[$];
  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  int mismatches = 0;
  int sine_count = 0;
  int cosine_count = 0;
  int full_scale_count = 0;
  int quiet_cycles = 0;

  // Signed Q4.59 product, magnitude rounded half away from zero.
  function automatic logic [63:0] q59_mul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] prod;
    ma = a[63] ? 64'd0 - a : a;
    mb = b[63] ? 64'd0 - b : b;
    prod = {64'd0, ma} * {64'd0, mb};
    prod = prod + (128'd1 << 58);
    return (a[63] ^ b[63]) ? 64'd0 - prod[122:59] : prod[122:59];
  endfunction

  function automatic logic [31:0] series_value(input logic op, input logic [31:0] angle);
    logic [63:0] a;
    logic [63:0] amag;
    logic [63:0] turns;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] coef;
    logic [63:0] mag;
    logic [63:0] r;
    logic        neg;
    a = {{32{angle[31]}}, angle};
    neg = a[63];
    amag = neg ? 64'd0 - a : a;
    turns = (amag + {32'd0, HALF_TURN_Q24}) / {32'd0, TWOPI_Q24};
    x = a << 35;
    x = neg ? x + turns * TWOPI_Q59 : x - turns * TWOPI_Q59;
    x2 = q59_mul(x, x);
    term = (op == OP_COSINE) ? ONE_Q59 : x;
    sum = term;
    for (int i = 1; i < SERIES_TERMS; i++) begin
      n = (op == OP_COSINE) ? 64'(2 * i) : 64'(2 * i + 1);
      d = n * (n - 64'd1);
      coef = (x2 + d / 64'd2) / d;
      term = 64'd0 - q59_mul(term, coef);
      sum = sum + term;
    end
    neg = sum[63];
    mag = neg ? 64'd0 - sum : sum;
    r = (mag + (64'd1 << 28)) >> 29;
    if (r > {32'd0, FULL_SCALE}) r = {32'd0, FULL_SCALE};
    return neg ? 32'd0 - r[31:0] : r[31:0];
  endfunction

  task automatic send_request(input logic op, input logic [31:0] angle);
    series_result_t exp_res;
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req.valid <= 1'b1;
    req.op    <= op;
    req.angle <= angle;
    do @(posedge clk_i); while (!req.ready);
    exp_res.op = op;
    exp_res.angle = angle;
    exp_res.value = series_value(op, angle);
    pending_results.push_back(exp_res);
    if (op == OP_COSINE) cosine_count++;
    else sine_count++;
  endtask

  task automatic stop_requests();
    @(negedge clk_i);
    req.valid <= 1'b0;
  endtask

  // Angles that matter for reduction and for the series tails.
  function automatic logic [31:0] pick_angle();
    longint v;
    longint turns;
    case ($urandom_range(3))
      0: v = longint'($signed($urandom()));
      1: v = longint'($urandom_range(8 * TWOPI_Q24)) - 4 * longint'(TWOPI_Q24);
      2: begin
        // straddle the point where the turn count steps
        turns = $urandom_range(19);
        v = turns * TWOPI_Q24 + HALF_TURN_Q24 + $urandom_range(8) - 4;
        if ($urandom_range(1)) v = -v;
      end
      default: begin
        turns = $urandom_range(70);
        v = turns * HALF_PI_Q24 + $urandom_range(64) - 32;
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v[31:0];
  endfunction

  task automatic test_directed_angles();
    logic [31:0] angles[12];
    angles = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               HALF_PI_Q24, 32'd0 - HALF_PI_Q24, HALF_TURN_Q24, HALF_TURN_Q24 + 32'd1,
               32'd0 - HALF_TURN_Q24, 32'd0 - HALF_TURN_Q24 - 32'd1, TWOPI_Q24};
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    foreach (angles[i]) begin
      send_request(OP_SINE, angles[i]);
      send_request(OP_COSINE, angles[i]);
    end
  endtask

  task automatic test_random_angles(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    repeat (count) send_request(logic'($urandom_range(1)), pick_angle());
  endtask

  always @(negedge clk_i) begin
    rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  always @(posedge clk_i) begin
    series_result_t exp_res;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%0d", $signed(rsp.value));
      end else begin
        exp_res = pending_results.pop_front();
        if (rsp.value !== exp_res.value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch op=%0b angle=%h: expected %0d (%h), got %0d (%h)",
                     exp_res.op, exp_res.angle, $signed(exp_res.value), exp_res.value,
                     $signed(rsp.value), rsp.value);
        end
        if (exp_res.value == FULL_SCALE || exp_res.value == 32'd0 - FULL_SCALE)
          full_scale_count++;
      end
    end
  end

  // Stall watchdog: any request or result accepted restarts the count.
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.op    = OP_SINE;
    req.angle = '0;
    rsp.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_angles();
    test_random_angles(156, 0, 0);
    test_random_angles(156, 84, 0);
    test_random_angles(156, 0, 84);
    test_random_angles(156, 24, 24);
    stop_requests();

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    mismatches += pending_results.size();
    $display("Ran %0d sine and %0d cosine requests (directed extremes, turn edges, random)",
             sine_count, cosine_count);
    $display("under four idle/stall patterns; %0d results at full scale, %0d mismatches.",
             full_scale_count, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
